// File: rtl/frac_ar_pkg.sv
// ----------------------------------------------------------------------------
// frac_ar_pkg
// shared types for the fraction arithmetic and reduction block
// ----------------------------------------------------------------------------
`default_nettype none

package frac_ar_pkg;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVA,
    ST_DIVB,
    ST_MUL,
    ST_COMB,
    ST_NORM,
    ST_WHOLE,
    ST_GCD,
    ST_GSTEP,
    ST_RDEN,
    ST_RNUM,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    PATH_MUL,
    PATH_DIV,
    PATH_QA,
    PATH_QB,
    PATH_CROSS
  } path_t;

  localparam int OUT_W = 32;
  localparam int DEN_W = 31;

endpackage

`default_nettype wire

// File: rtl/frac_ar_div.sv
// ----------------------------------------------------------------------------
// frac_ar_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module frac_ar_div #(
  parameter int UW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [UW-1:0] dividend,
  input  logic [UW-1:0] divisor,
  output logic          done,
  output logic [UW-1:0] quotient,
  output logic [UW-1:0] remainder
);

  localparam int CW = $clog2(UW + 1);

  logic [UW-1:0] rem_r;
  logic [UW-1:0] quo;
  logic [UW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [UW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo[UW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(UW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo   <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      // restoring step
      rem_r <= fits ? UW'(trial - {1'b0, dvs}) : trial[UW-1:0];
      quo   <= {quo[UW-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// File: rtl/frac_ar_mul.sv
// ----------------------------------------------------------------------------
// frac_ar_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module frac_ar_mul #(
  parameter int MW = 17,
  parameter int SW = 34
) (
  input  logic                 clk,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic signed [SW-1:0] p
);

  logic signed [2*MW-1:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= SW'(full);
  end

endmodule

`default_nettype wire

// File: rtl/fraction_arith_reduce_core.sv
// ----------------------------------------------------------------------------
// fraction_arith_reduce_core
// rational add/sub/mul/div of two signed fractions with gcd reduction
// ----------------------------------------------------------------------------
// sequence: each division runs on the single shared divider, one quotient bit
// per cycle; an add or sub may first run up to two divisibility checks, then
// each item without error runs a whole-part division and, if the remainder is
// not zero, the Euclid steps of the gcd and two reducing divisions
// throughput: one item at a time, set by the single shared divider
// reset: rst synchronous active high, returns the sequencer to idle and
// drops out_valid; datapath registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_arith_reduce_core #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic signed [VALUE_WIDTH-1:0] num_a,
  input  logic signed [VALUE_WIDTH-1:0] den_a,
  input  logic signed [VALUE_WIDTH-1:0] num_b,
  input  logic signed [VALUE_WIDTH-1:0] den_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            whole_part,
  output logic signed [31:0]            frac_num,
  output logic [30:0]                   frac_den,
  output logic                          is_integer,
  output logic                          status
);

  import frac_ar_pkg::*;

  // operand width with room for quotients like da/db, and the wide working
  // width that holds products, sums and the saturation bounds
  localparam int MW = VALUE_WIDTH + 1;
  localparam int SW = (2*VALUE_WIDTH + 2 > 34) ? 2*VALUE_WIDTH + 2 : 34;
  localparam int UW = SW - 1;

  localparam logic signed [SW-1:0] WMAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] WMIN = -WMAX - $signed(SW'(1));

  state_t state, state_next;
  path_t  path;
  op_t    op;

  logic signed [MW-1:0] na, da, nb, db, q;
  logic signed [SW-1:0] prod [3];
  logic signed [SW-1:0] num, den, whole;
  logic                 numneg;
  logic [UW-1:0]        gx, gy, fd;
  logic [1:0]           mstep;

  // shared units
  logic                 div_start, div_done;
  logic [UW-1:0]        div_a, div_b, div_q, div_r;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [SW-1:0] mul_p;

  logic                 err;
  logic [1:0]           nprod;
  logic signed [SW-1:0] qsigned;
  logic signed [MW-1:0] qfix;

  function automatic logic [UW-1:0] mag_s(input logic signed [SW-1:0] v);
    mag_s = v[SW-1] ? UW'(-v) : UW'(v);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v;
    if (v > WMAX) t = WMAX;
    if (v < WMIN) t = WMIN;
    sat32 = t[31:0];
  endfunction

  frac_ar_div #(.UW(UW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  frac_ar_mul #(.MW(MW), .SW(SW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign err = (da == '0) || (db == '0) || ((op == OP_DIV) && (nb == '0));

  // divider quotient at operand width and as a non-negative wide value; the sign is applied where each is used
  assign qfix    = MW'(div_q);
  assign qsigned = $signed({1'b0, div_q});

  // products needed per path
  always_comb begin
    case (path)
      PATH_QA, PATH_QB: nprod = 2'd1;
      PATH_CROSS:       nprod = 2'd3;
      default:          nprod = 2'd2;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    mul_a = na;
    mul_b = nb;
    case (path)
      PATH_MUL: begin
        if (mstep != 2'd0) begin
          mul_a = da;
          mul_b = db;
        end
      end
      PATH_DIV: begin
        mul_a = (mstep == 2'd0) ? na : da;
        mul_b = (mstep == 2'd0) ? db : nb;
      end
      PATH_QA: begin
        mul_a = nb;
        mul_b = q;
      end
      PATH_QB: begin
        mul_a = na;
        mul_b = q;
      end
      PATH_CROSS: begin
        case (mstep)
          2'd0:    begin mul_a = na; mul_b = db; end
          2'd1:    begin mul_a = nb; mul_b = da; end
          default: begin mul_a = da; mul_b = db; end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and divider requests
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_a      = '0;
    div_b      = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (err) begin
          state_next = ST_OUT;
        end else if (op == OP_MUL || op == OP_DIV) begin
          state_next = ST_MUL;
        end else if (da == db) begin
          state_next = ST_NORM;
        end else begin
          // does db divide da
          div_start  = 1'b1;
          div_a      = mag_s(SW'(da));
          div_b      = mag_s(SW'(db));
          state_next = ST_DIVA;
        end
      end
      ST_DIVA: begin
        if (div_done) begin
          if (div_r == '0) begin
            state_next = ST_MUL;
          end else begin
            // does da divide db
            div_start  = 1'b1;
            div_a      = mag_s(SW'(db));
            div_b      = mag_s(SW'(da));
            state_next = ST_DIVB;
          end
        end
      end
      ST_DIVB: begin
        if (div_done) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mstep == nprod) state_next = ST_COMB;
      end
      ST_COMB: begin
        state_next = ST_NORM;
      end
      ST_NORM: begin
        // whole part and remainder by magnitudes, signs fixed afterwards
        div_start  = 1'b1;
        div_a      = mag_s(num);
        div_b      = mag_s(den);
        state_next = ST_WHOLE;
      end
      ST_WHOLE: begin
        if (div_done) state_next = (div_r == '0) ? ST_OUT : ST_GCD;
      end
      ST_GCD: begin
        div_start = 1'b1;
        if (gy == '0) begin
          div_a      = mag_s(den);
          div_b      = gx;
          state_next = ST_RDEN;
        end else begin
          div_a      = gx;
          div_b      = gy;
          state_next = ST_GSTEP;
        end
      end
      ST_GSTEP: begin
        if (div_done) state_next = ST_GCD;
      end
      ST_RDEN: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_a      = fd;
          div_b      = gx;
          state_next = ST_RNUM;
        end
      end
      ST_RNUM: begin
        if (div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op    <= op_t'(operation);
          na    <= MW'(num_a);
          da    <= MW'(den_a);
          nb    <= MW'(num_b);
          db    <= MW'(den_b);
          mstep <= 2'd0;
        end
      end
      ST_CHECK: begin
        if (err) begin
          whole_part <= '0;
          frac_num   <= '0;
          frac_den   <= 31'd1;
          is_integer <= 1'b0;
          status     <= 1'b1;
        end else begin
          case (op)
            OP_MUL:  path <= PATH_MUL;
            OP_DIV:  path <= PATH_DIV;
            default: path <= PATH_CROSS;
          endcase
          // equal denominators are kept as they are
          num <= (op == OP_SUB) ? SW'(na) - SW'(nb) : SW'(na) + SW'(nb);
          den <= SW'(da);
        end
      end
      ST_DIVA: begin
        if (div_done && div_r == '0) begin
          path <= PATH_QA;
          q    <= (da[MW-1] ^ db[MW-1]) ? -qfix : qfix;
        end
      end
      ST_DIVB: begin
        if (div_done && div_r == '0) begin
          path <= PATH_QB;
          q    <= (da[MW-1] ^ db[MW-1]) ? -qfix : qfix;
        end
      end
      ST_MUL: begin
        mstep <= mstep + 2'd1;
        if (mstep != 2'd0) prod[mstep - 2'd1] <= mul_p;
      end
      ST_COMB: begin
        case (path)
          PATH_QA: begin
            num <= (op == OP_SUB) ? SW'(na) - prod[0] : prod[0] + SW'(na);
            den <= SW'(da);
          end
          PATH_QB: begin
            num <= (op == OP_SUB) ? prod[0] - SW'(nb) : prod[0] + SW'(nb);
            den <= SW'(db);
          end
          PATH_CROSS: begin
            num <= (op == OP_SUB) ? prod[0] - prod[1] : prod[0] + prod[1];
            den <= prod[2];
          end
          default: begin
            num <= prod[0];
            den <= prod[1];
          end
        endcase
      end
      ST_NORM: begin
        // positive denominator from here on
        numneg <= num[SW-1] ^ den[SW-1];
        if (den[SW-1]) begin
          num <= -num;
          den <= -den;
        end
      end
      ST_WHOLE: begin
        if (div_done) begin
          whole <= numneg ? -qsigned : qsigned;
          gx    <= div_r;
          gy    <= UW'(den);
          fd    <= div_r;
          if (div_r == '0) begin
            whole_part <= sat32(numneg ? -qsigned : qsigned);
            frac_num   <= '0;
            frac_den   <= 31'd1;
            is_integer <= 1'b1;
            status     <= 1'b0;
          end
        end
      end
      ST_GSTEP: begin
        if (div_done) begin
          gx <= gy;
          gy <= div_r;
        end
      end
      ST_RDEN: begin
        if (div_done) frac_den <= div_q[30:0];
      end
      ST_RNUM: begin
        if (div_done) begin
          whole_part <= sat32(whole);
          frac_num   <= (whole == '0 && numneg) ? -div_q[31:0] : div_q[31:0];
          is_integer <= 1'b0;
          status     <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

endmodule

`default_nettype wire

// File: rtl/frac_ar_chk.sv
// ----------------------------------------------------------------------------
// frac_ar_chk
// port-level checks for the fraction arithmetic block
// ----------------------------------------------------------------------------
`default_nettype none

module frac_ar_chk #(
  parameter int VALUE_WIDTH = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    operation,
  input logic signed [VALUE_WIDTH-1:0] num_a,
  input logic signed [VALUE_WIDTH-1:0] den_a,
  input logic signed [VALUE_WIDTH-1:0] num_b,
  input logic signed [VALUE_WIDTH-1:0] den_b,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [31:0]            whole_part,
  input logic signed [31:0]            frac_num,
  input logic [30:0]                   frac_den,
  input logic                          is_integer,
  input logic                          status
);

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(whole_part) && $stable(frac_num)
      && $stable(frac_den) && $stable(status))
    else $error("result changed while stalled");

  // error result has fixed fields
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> whole_part == 0 && frac_num == 0 && frac_den == 31'd1
      && !is_integer)
    else $error("bad error result");

  // integer result has unit denominator
  a_int: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_integer |-> frac_num == 0 && frac_den == 31'd1 && !status)
    else $error("bad integer result");

  // one item in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("accepted while busy");

endmodule

bind fraction_arith_reduce_core frac_ar_chk #(.VALUE_WIDTH(VALUE_WIDTH)) u_frac_ar_chk (.*);

`default_nettype wire
